@@ src/ndcg_pkg.sv @@
// ----------------------------------------------------------------------------
// ndcg_pkg
// Shared types, constants and gain function for the NDCG ranking score block.
// ----------------------------------------------------------------------------
package ndcg_pkg;

   localparam int MAX_LEN_DEF        = 1024;
   localparam int DISC_FRAC_BITS_DEF = 16;

   localparam int REL_W       = 8;
   localparam int REL_FRAC_W  = 4;
   localparam int RATIO_W     = 18;
   localparam int RATIO_FRAC  = 16;
   localparam int SUM_W       = 48;
   localparam int GAIN_W      = 32;
   localparam int MUL_W       = 32;
   localparam int MANT_W      = 31;   // log2 mantissa, Q1.30
   localparam int MANT_FRAC   = 30;
   localparam int LOG_FRAC_W  = 32;   // fraction bits of log2 result
   localparam int ITER_W      = 5;
   localparam int LIN_SHIFT   = 12;   // Q4.4 -> Q.16
   localparam int ONE_Q16     = 65536;
   localparam int EXP_FRAC_W  = 17;

   localparam logic GAIN_LINEAR = 1'b0;
   localparam logic GAIN_EXP    = 1'b1;

   // 2^(k/16) in Q1.16
   localparam logic [EXP_FRAC_W-1:0] EXP_FRAC [16] = '{
      17'd65536,  17'd68438,  17'd71468,  17'd74632,
      17'd77936,  17'd81386,  17'd84990,  17'd88752,
      17'd92682,  17'd96785,  17'd101070, 17'd105545,
      17'd110218, 17'd115097, 17'd120193, 17'd125515
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG_SQ,
      ST_LOG_ADJ,
      ST_WDIV_GO,
      ST_WDIV_RUN,
      ST_TERM_I,
      ST_ACC_I,
      ST_TERM_P,
      ST_ACC_P,
      ST_CHECK,
      ST_RDIV_RUN,
      ST_EMIT
   } state_type;

   // gain in Q.16
   function automatic logic [GAIN_W-1:0] gain_of(input logic [REL_W-1:0] rel,
                                                 input logic mode);
      logic [GAIN_W-1:0] g;
      if (mode == GAIN_LINEAR) begin
         g = GAIN_W'(rel) << LIN_SHIFT;
      end else begin
         g = (GAIN_W'(EXP_FRAC[rel[REL_FRAC_W-1:0]]) << rel[REL_W-1:REL_FRAC_W])
             - GAIN_W'(ONE_Q16);
      end
      return g;
   endfunction

endpackage

@@ src/ndcg_req_if.sv @@
// ----------------------------------------------------------------------------
// ndcg_req_if
// Input channel: one ranked position per transaction.
// ----------------------------------------------------------------------------
interface ndcg_req_if;
   import ndcg_pkg::*;

   logic             valid;
   logic             ready;
   logic [REL_W-1:0] ideal_relevance;
   logic [REL_W-1:0] predicted_relevance;
   logic             last_position;

   modport source (output valid, output ideal_relevance, output predicted_relevance,
                   output last_position, input ready);
   modport sink   (input valid, input ideal_relevance, input predicted_relevance,
                   input last_position, output ready);
endinterface

@@ src/ndcg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ndcg_rsp_if
// Result channel: one score per ranked list.
// ----------------------------------------------------------------------------
interface ndcg_rsp_if;
   import ndcg_pkg::*;

   logic               valid;
   logic               ready;
   logic [RATIO_W-1:0] ndcg_value;
   logic               zero_sum;
   logic               list_overflow;

   modport source (output valid, output ndcg_value, output zero_sum,
                   output list_overflow, input ready);
   modport sink   (input valid, input ndcg_value, input zero_sum,
                   input list_overflow, output ready);
endinterface

@@ src/ndcg_mul.sv @@
// ----------------------------------------------------------------------------
// ndcg_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module ndcg_mul (
   input  logic                          clock,
   input  logic [ndcg_pkg::MUL_W-1:0]    a,
   input  logic [ndcg_pkg::MUL_W-1:0]    b,
   output logic [2*ndcg_pkg::MUL_W-1:0]  product
);
   import ndcg_pkg::*;

   logic [2*MUL_W-1:0] prod_ff;
   logic [2*MUL_W-1:0] prod_in;

   assign prod_in = a * b;
   assign product = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

@@ src/ndcg_div.sv @@
// ----------------------------------------------------------------------------
// ndcg_div
// Shared restoring divider, one quotient bit per cycle. The caller supplies
// the high part of the dividend (already below the divisor) and the low bits
// left-aligned.
// ----------------------------------------------------------------------------
module ndcg_div #(
   parameter int DEN_W = 48,
   parameter int Q_W   = 25
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [$clog2(Q_W+1)-1:0] steps,
   input  logic [DEN_W-1:0]         rem_init,
   input  logic [Q_W-1:0]           lo_bits,
   input  logic [DEN_W-1:0]         divisor,
   output logic                     done,
   output logic [Q_W-1:0]           quotient
);
   import ndcg_pkg::*;

   localparam int STEP_W = $clog2(Q_W+1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [Q_W-1:0]    lo_ff, lo_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   assign trial = {rem_ff, lo_ff[Q_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = rem_init;
         lo_in  = lo_bits;
         q_in   = '0;
         den_in = divisor;
         cnt_in = steps;
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         lo_in   = lo_ff << 1;
         q_in    = {q_ff[Q_W-2:0], ge};
         cnt_in  = cnt_ff - STEP_W'(1);
         done_in = (cnt_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

@@ src/ndcg_ranking_score.sv @@
// ----------------------------------------------------------------------------
// ndcg_ranking_score
// Normalized discounted cumulative gain over one ranked list.
// req_ch carries one list position per transaction (ideal and predicted
// relevance, Q4.4, plus a last flag); rsp_ch returns one score per list,
// predicted DCG over ideal DCG in Q2.16. csr_write_enable/csr_write_data set
// gain_mode (0 linear, 1 exponential); the user must write it only while the
// block is idle, and the block itself does not enforce this. For each position,
// 32 squarings on the shared multiplier form log2 of the position, the shared
// divider gives the discount weight one bit a cycle, then two multiply-adds.
// Position 0 in linear mode skips the log and the divide; positions past
// MAX_LEN skip all of it. The last position adds the final 18-bit divide
// (skipped when the score is zero or saturated).
// req_ch.ready is high only between positions. A finished score sits in the
// rsp_ch output register; the next list is accepted while it waits, and the
// block stalls only when a second score is ready before the first is taken.
// Reset clears the sums, position count, overflow flag and gain_mode.
// ----------------------------------------------------------------------------
module ndcg_ranking_score #(
   parameter int MAX_LEN            = ndcg_pkg::MAX_LEN_DEF,
   parameter int DISCOUNT_FRAC_BITS = ndcg_pkg::DISC_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   ndcg_req_if.sink   req_ch,
   ndcg_rsp_if.source rsp_ch
);
   import ndcg_pkg::*;

   localparam int DFB     = DISCOUNT_FRAC_BITS;
   localparam int CNT_W   = $clog2(MAX_LEN+1);
   localparam int N_W     = $clog2(MAX_LEN+2);
   localparam int K_W     = $clog2(N_W);
   localparam int LG_W    = K_W + LOG_FRAC_W;
   localparam int W_W     = DFB + 1;
   localparam int DIV_Q_W = (DFB + 1 > RATIO_W) ? DFB + 1 : RATIO_W;
   localparam int STEP_W  = $clog2(DIV_Q_W+1);

   state_type state_ff, state_in;

   logic                gain_mode_ff, gain_mode_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    ideal_sum_ff, ideal_sum_in;
   logic [SUM_W-1:0]    pred_sum_ff, pred_sum_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [REL_W-1:0]      ideal_rel_ff, ideal_rel_in;
   logic [REL_W-1:0]      pred_rel_ff, pred_rel_in;
   logic                  last_ff, last_in;
   logic                  mode_ff, mode_in;
   logic [MANT_W-1:0]     y_ff, y_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic [LOG_FRAC_W-1:0] frac_ff, frac_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [W_W-1:0]        weight_ff, weight_in;
   logic [RATIO_W-1:0]    res_ratio_ff, res_ratio_in;
   logic                  res_zero_ff, res_zero_in;
   logic [RATIO_W-1:0]    rsp_ratio_ff, rsp_ratio_in;
   logic                  rsp_zero_ff, rsp_zero_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                 req_fire;
   logic                 rsp_free;
   logic [N_W-1:0]       n_w;
   logic [K_W-1:0]       k_w;
   logic [LG_W-1:0]      lg_w;
   logic [MUL_W-1:0]     sq_w;
   logic [SUM_W:0]       ideal_add, pred_add;
   logic                 zero_w;

   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [2*MUL_W-1:0]   mul_prod;
   logic                 div_start;
   logic [STEP_W-1:0]    div_steps;
   logic [SUM_W-1:0]     div_rem_init;
   logic [DIV_Q_W-1:0]   div_lo;
   logic [SUM_W-1:0]     div_den;
   logic                 div_done;
   logic [DIV_Q_W-1:0]   div_q;

   ndcg_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_prod)
   );

   ndcg_div #(
      .DEN_W (SUM_W),
      .Q_W   (DIV_Q_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .rem_init (div_rem_init),
      .lo_bits  (div_lo),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // position number whose log2 gives the discount
   assign n_w = N_W'(count_ff) + ((gain_mode_ff == GAIN_EXP) ? N_W'(2) : N_W'(1));

   always_comb begin
      k_w = '0;
      for (int b = 0; b < N_W; b++) begin
         if (n_w[b]) begin
            k_w = K_W'(b);
         end
      end
   end

   assign lg_w = {k_ff, frac_ff};
   assign sq_w = mul_prod[2*MANT_FRAC+1:MANT_FRAC];

   assign ideal_add = {1'b0, ideal_sum_ff} + (SUM_W+1)'(mul_prod >> DFB);
   assign pred_add  = {1'b0, pred_sum_ff} + (SUM_W+1)'(mul_prod >> DFB);
   assign zero_w    = (ideal_sum_ff == '0) || (pred_sum_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (count_ff >= CNT_W'(MAX_LEN)) begin
                  state_in = ST_CHECK;
               end else if (gain_mode_ff == GAIN_LINEAR && count_ff == '0) begin
                  state_in = ST_TERM_I;
               end else begin
                  state_in = ST_LOG_SQ;
               end
            end
         end
         ST_LOG_SQ:  state_in = ST_LOG_ADJ;
         ST_LOG_ADJ: begin
            state_in = (iter_ff == ITER_W'(LOG_FRAC_W-1)) ? ST_WDIV_GO : ST_LOG_SQ;
         end
         ST_WDIV_GO: state_in = ST_WDIV_RUN;
         ST_WDIV_RUN: begin
            if (div_done) begin
               state_in = ST_TERM_I;
            end
         end
         ST_TERM_I:  state_in = ST_ACC_I;
         ST_ACC_I:   state_in = ST_TERM_P;
         ST_TERM_P:  state_in = ST_ACC_P;
         ST_ACC_P:   state_in = ST_CHECK;
         ST_CHECK: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (zero_w || ({2'b00, pred_sum_ff} >= {ideal_sum_ff, 2'b00})) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_RDIV_RUN;
            end
         end
         ST_RDIV_RUN: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and unit controls
   always_comb begin
      gain_mode_in = csr_write_enable ? csr_write_data : gain_mode_ff;
      count_in     = count_ff;
      ideal_sum_in = ideal_sum_ff;
      pred_sum_in  = pred_sum_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_ch.ready) ? 1'b0 : rsp_valid_ff;
      ideal_rel_in = ideal_rel_ff;
      pred_rel_in  = pred_rel_ff;
      last_in      = last_ff;
      mode_in      = mode_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      frac_in      = frac_ff;
      iter_in      = iter_ff;
      weight_in    = weight_ff;
      res_ratio_in = res_ratio_ff;
      res_zero_in  = res_zero_ff;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mul_a        = {1'b0, y_ff};
      mul_b        = {1'b0, y_ff};
      div_start    = 1'b0;
      div_steps    = STEP_W'(RATIO_W);
      div_rem_init = pred_sum_ff >> 2;
      div_lo       = DIV_Q_W'({pred_sum_ff[1:0], {RATIO_FRAC{1'b0}}}) << (DIV_Q_W - RATIO_W);
      div_den      = ideal_sum_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ideal_rel_in = req_ch.ideal_relevance;
               pred_rel_in  = req_ch.predicted_relevance;
               last_in      = req_ch.last_position;
               mode_in      = gain_mode_ff;
               if (count_ff >= CNT_W'(MAX_LEN)) begin
                  ovf_in = 1'b1;
               end
               weight_in = W_W'(1) << DFB;
               y_in      = MANT_W'(n_w) << (MANT_FRAC - int'(k_w));
               k_in      = k_w;
               frac_in   = '0;
               iter_in   = '0;
            end
         end
         ST_LOG_ADJ: begin
            // renormalize the squared mantissa; an overflow past 2 is a 1 bit
            if (sq_w[MUL_W-1]) begin
               y_in    = sq_w[MUL_W-1:1];
               frac_in = {frac_ff[LOG_FRAC_W-2:0], 1'b1};
            end else begin
               y_in    = sq_w[MANT_W-1:0];
               frac_in = {frac_ff[LOG_FRAC_W-2:0], 1'b0};
            end
            iter_in = iter_ff + ITER_W'(1);
         end
         ST_WDIV_GO: begin
            // (2^(DFB+32) + lg/2) / lg; the high part is 2^31 + lg >> (DFB+2)
            div_start    = 1'b1;
            div_steps    = STEP_W'(W_W);
            div_rem_init = (SUM_W'(1) << (LOG_FRAC_W-1)) | SUM_W'(lg_w >> (DFB+2));
            div_lo       = DIV_Q_W'(lg_w[DFB+1:1]) << (DIV_Q_W - W_W);
            div_den      = SUM_W'(lg_w);
         end
         ST_WDIV_RUN: begin
            if (div_done) begin
               weight_in = div_q[W_W-1:0];
            end
         end
         ST_TERM_I: begin
            mul_a = gain_of(ideal_rel_ff, mode_ff);
            mul_b = MUL_W'(weight_ff);
         end
         ST_ACC_I: begin
            ideal_sum_in = ideal_add[SUM_W] ? '1 : ideal_add[SUM_W-1:0];
         end
         ST_TERM_P: begin
            mul_a = gain_of(pred_rel_ff, mode_ff);
            mul_b = MUL_W'(weight_ff);
         end
         ST_ACC_P: begin
            pred_sum_in = pred_add[SUM_W] ? '1 : pred_add[SUM_W-1:0];
            count_in    = count_ff + CNT_W'(1);
         end
         ST_CHECK: begin
            res_zero_in = zero_w;
            if (zero_w) begin
               res_ratio_in = '0;
            end else if ({2'b00, pred_sum_ff} >= {ideal_sum_ff, 2'b00}) begin
               res_ratio_in = '1;
            end else if (last_ff) begin
               div_start = 1'b1;
            end
         end
         ST_RDIV_RUN: begin
            if (div_done) begin
               res_ratio_in = div_q[RATIO_W-1:0];
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ratio_in = res_ratio_ff;
               rsp_zero_in  = res_zero_ff;
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               ideal_sum_in = '0;
               pred_sum_in  = '0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_mode_ff <= GAIN_LINEAR;
         count_ff     <= '0;
         ideal_sum_ff <= '0;
         pred_sum_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_mode_ff <= gain_mode_in;
         count_ff     <= count_in;
         ideal_sum_ff <= ideal_sum_in;
         pred_sum_ff  <= pred_sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ideal_rel_ff <= ideal_rel_in;
      pred_rel_ff  <= pred_rel_in;
      last_ff      <= last_in;
      mode_ff      <= mode_in;
      y_ff         <= y_in;
      k_ff         <= k_in;
      frac_ff      <= frac_in;
      iter_ff      <= iter_in;
      weight_ff    <= weight_in;
      res_ratio_ff <= res_ratio_in;
      res_zero_ff  <= res_zero_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_zero_ff  <= rsp_zero_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ndcg_value    = rsp_ratio_ff;
   assign rsp_ch.zero_sum      = rsp_zero_ff;
   assign rsp_ch.list_overflow = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WDIV_RUN || state_ff == ST_RDIV_RUN))
      else $error("divider finished outside a wait state");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result raised outside the emit step");

   a_zero_sum_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zero_ff) |-> (rsp_ratio_ff == '0))
      else $error("zero-sum result carries a nonzero score");

   a_list_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |=>
         (count_ff == '0 && ideal_sum_ff == '0 && pred_sum_ff == '0 && !ovf_ff))
      else $error("list state not cleared after a result");
`endif
endmodule
